// ----- rtl/core/fir_filter_direct_form_unit_assert.svh -----
// Assertion macros used by the FIR filter top module.
`ifndef FIR_FILTER_DIRECT_FORM_UNIT_ASSERT_SVH
`define FIR_FILTER_DIRECT_FORM_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FIRDF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FIRDF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/firdf_pkg.sv -----
// Types and constants shared by the FIR filter modules.
`default_nettype none

package firdf_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int PROD_W    = 32;
	// Eight full-scale Q2.30 products need three more bits of headroom.
	localparam int ACC_W     = 35;
	localparam int CFG_IDX_W = 4;
	localparam int FRAC_W    = 15;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
	localparam logic [FRAC_W-1:0]          ROUND_BIAS = 15'h4000;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic                    vld;
		logic signed [ACC_W-1:0] psum;
	} cell_link_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] filtered;
		logic                       saturated;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/core/firdf_cell.sv -----
// One tap cell: coefficient, delay stage and operand skew (not in cell 0), multiplier and partial-sum adder.
`default_nettype none

module firdf_cell #(
	parameter int IDX = 0
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   en,
	input  wire logic                                   acc,
	input  wire logic                                   cfg_we,
	input  wire logic [firdf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [firdf_pkg::SAMPLE_W-1:0]         cfg_data,
	input  wire firdf_pkg::sample_t                     tap_in,
	output firdf_pkg::sample_t                          tap_out,
	input  wire firdf_pkg::cell_link_t                  link_in,
	output firdf_pkg::cell_link_t                       link_out
);

	localparam int IW = firdf_pkg::CFG_IDX_W;
	localparam logic [IW-1:0] CELL_IDX = IW'(IDX);

	firdf_pkg::sample_t                        coeff_q;
	firdf_pkg::sample_t                        mul_op;
	logic signed [firdf_pkg::PROD_W-1:0]       prod_q;
	logic signed [firdf_pkg::ACC_W-1:0]        psum_q;
	logic                                      vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= '0;
		end else if (cfg_we && (cfg_index == CELL_IDX)) begin
			coeff_q <= cfg_data;
		end
	end

	generate
		if (IDX == 0) begin : g_head
			// The current sample is multiplied in the cycle it is transferred.
			assign tap_out = tap_in;
			assign mul_op  = tap_in;
		end else begin : g_body
			firdf_pkg::sample_t delay_q;
			firdf_pkg::sample_t skew_q [IDX];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					delay_q <= '0;
				end else if (acc) begin
					delay_q <= tap_in;
				end
			end

			// The operand passes through the skew registers skew_q so that its product meets the partial sum.
			always_ff @(posedge clk) begin
				if (en) begin
					skew_q[0] <= delay_q;
					for (int i = 1; i < IDX; i++) begin
						skew_q[i] <= skew_q[i-1];
					end
				end
			end

			assign tap_out = delay_q;
			assign mul_op  = skew_q[IDX-1];
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= mul_op * coeff_q;
			psum_q <= link_in.psum + firdf_pkg::ACC_W'(prod_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= link_in.vld;
		end
	end

	assign link_out = '{vld: vld_q, psum: psum_q};

endmodule

`default_nettype wire

// ----- rtl/core/firdf_round.sv -----
// Round-half-up at bit 15 and saturation of the full-precision sum to Q1.15.
`default_nettype none

module firdf_round (
	input  wire logic signed [firdf_pkg::ACC_W-1:0] psum,
	output firdf_pkg::result_t                      res
);

	localparam int BW = firdf_pkg::ACC_W + 1;
	localparam int YW = BW - firdf_pkg::FRAC_W;
	localparam int HW = YW - firdf_pkg::FRAC_W;

	logic signed [BW-1:0] biased;
	logic signed [YW-1:0] y;
	logic                 fits;

	always_comb begin
		biased = {psum[firdf_pkg::ACC_W-1], psum} + BW'(firdf_pkg::ROUND_BIAS);
		y      = biased[BW-1:firdf_pkg::FRAC_W];
		// The value fits in 16 bits when every bit above bit 15 repeats the sign.
		fits   = (y[YW-1:firdf_pkg::FRAC_W] == {HW{y[firdf_pkg::FRAC_W]}});
		res.saturated = !fits;
		if (fits) begin
			res.filtered = y[firdf_pkg::SAMPLE_W-1:0];
		end else if (y[YW-1]) begin
			res.filtered = firdf_pkg::SAMPLE_MIN;
		end else begin
			res.filtered = firdf_pkg::SAMPLE_MAX;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/fir_filter_direct_form_unit.sv -----
// Direct-form FIR filter: a row of tap cells with a skewed partial-sum chain.
// Each result passes the cells' product and partial-sum registers, then the output register.
// Throughput: one sample per cycle while in_stall is low, set by the cells and skid register.
// The input stalls only while the skid register holds a result behind a stalled output.
// Reset clears the delay line and all coefficients to zero and empties the pipeline.
`default_nettype none
`include "fir_filter_direct_form_unit_assert.svh"

module fir_filter_direct_form_unit #(
	parameter int TAP_COUNT = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [firdf_pkg::SAMPLE_W-1:0] sample_in,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [firdf_pkg::SAMPLE_W-1:0]    filtered_out,
	output logic                                     saturated,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [firdf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [firdf_pkg::SAMPLE_W-1:0]      cfg_data
);

	logic                  en;
	logic                  acc;
	logic                  cfg_we;
	logic                  in_vld_s1;
	firdf_pkg::sample_t    taps [TAP_COUNT];
	firdf_pkg::cell_link_t link [TAP_COUNT+1];
	logic [TAP_COUNT:0]    vld_vec;
	firdf_pkg::result_t    rnd;
	firdf_pkg::result_t    out_res_q;
	firdf_pkg::result_t    skid_res_q;
	logic                  out_vld_q;
	logic                  skid_vld_q;

	assign en        = !skid_vld_q;
	assign in_stall  = skid_vld_q;
	assign acc       = in_valid && en;
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
		end else if (en) begin
			in_vld_s1 <= acc;
		end
	end

	assign taps[0]      = sample_in;
	assign link[0].vld  = in_vld_s1;
	assign link[0].psum = '0;

	generate
		for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
			assign vld_vec[k] = link[k].vld;
			if (k < TAP_COUNT - 1) begin : g_mid
				firdf_cell #(.IDX(k)) u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.en       (en),
					.acc      (acc),
					.cfg_we   (cfg_we),
					.cfg_index(cfg_index),
					.cfg_data (cfg_data),
					.tap_in   (taps[k]),
					.tap_out  (taps[k+1]),
					.link_in  (link[k]),
					.link_out (link[k+1])
				);
			end else begin : g_last
				firdf_cell #(.IDX(k)) u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.en       (en),
					.acc      (acc),
					.cfg_we   (cfg_we),
					.cfg_index(cfg_index),
					.cfg_data (cfg_data),
					.tap_in   (taps[k]),
					.tap_out  (),
					.link_in  (link[k]),
					.link_out (link[k+1])
				);
			end
		end
	endgenerate

	assign vld_vec[TAP_COUNT] = link[TAP_COUNT].vld;

	firdf_round u_round (
		.psum(link[TAP_COUNT].psum),
		.res (rnd)
	);

	// A result that arrives while the output register holds a stalled result parks in the skid register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (en) begin
			if (out_vld_q && out_stall) begin
				skid_vld_q <= link[TAP_COUNT].vld;
			end else begin
				out_vld_q <= link[TAP_COUNT].vld;
			end
		end else if (!out_stall) begin
			out_vld_q  <= 1'b1;
			skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (out_vld_q && out_stall) begin
				skid_res_q <= rnd;
			end else begin
				out_res_q <= rnd;
			end
		end else if (!out_stall) begin
			out_res_q <= skid_res_q;
		end
	end

	assign out_valid    = out_vld_q;
	assign filtered_out = out_res_q.filtered;
	assign saturated    = out_res_q.saturated;

	`FIRDF_ASSERT_SAME(a_skid_behind_out, skid_vld_q, out_vld_q, "skid holds a result with output empty")
	`FIRDF_ASSERT_NEXT(a_skid_fill, !skid_vld_q && out_vld_q && out_stall && link[TAP_COUNT].vld, skid_vld_q, "result lost at stalled output")
	`FIRDF_ASSERT_NEXT(a_chain_frozen, skid_vld_q, $stable(vld_vec), "cell chain moved while skid full")
	`FIRDF_ASSERT_SAME(a_sat_value, out_vld_q && out_res_q.saturated, out_res_q.filtered == firdf_pkg::SAMPLE_MAX || out_res_q.filtered == firdf_pkg::SAMPLE_MIN, "saturated result not at a range limit")

endmodule

`default_nettype wire
